/* src/apu_pkg.sv */
// Package for the alpha premultiply unit.
// It holds the channel format constants, the register map and the pipeline stage types.
// It has no dependencies.
package apu_pkg;

	localparam int CHANNEL_BITS = 16;
	localparam int NUM_LANES    = 3;
	localparam int PROD_W       = 2 * CHANNEL_BITS;
	localparam int NUM_W        = 2 * CHANNEL_BITS + 1;
	localparam int ERR_W        = 2 * CHANNEL_BITS + 4;
	localparam int DATA_W       = 32;
	localparam int ADDR_W       = 3;
	localparam int REG_IDX_LSB  = 2;

	localparam logic [CHANNEL_BITS-1:0] MAXV = {CHANNEL_BITS{1'b1}};

	typedef enum logic {
		REG_DIRECTION = 1'b0,
		REG_NONE      = 1'b1
	} apu_reg_t;

	typedef enum logic {
		DIR_PREMULTIPLY   = 1'b0,
		DIR_UNPREMULTIPLY = 1'b1
	} apu_dir_t;

	typedef struct packed {
		logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] col;
		logic [CHANNEL_BITS-1:0]                alpha;
		logic                                   last;
	} apu_pix_t;

	typedef struct packed {
		logic [NUM_LANES-1:0][NUM_W-1:0]        rem;
		logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] quo;
		logic [NUM_LANES-1:0][PROD_W-1:0]       prod;
		logic [NUM_LANES-1:0][CHANNEL_BITS:0]   pre;
		logic [NUM_LANES-1:0][CHANNEL_BITS-1:0] col;
		logic [NUM_LANES-1:0]                   sat;
		logic                                   azero;
		logic [CHANNEL_BITS-1:0]                alpha;
		logic                                   last;
	} apu_stage_t;

endpackage

/* src/apu_ifs.sv */
// Stream interfaces of the alpha premultiply unit: incoming pixels and converted results.
// Each carries valid, ready and one pixel. Depends on apu_pkg.
interface apu_pixel_if;
	logic                              valid;
	logic                              ready;
	logic [apu_pkg::CHANNEL_BITS-1:0]  red_in;
	logic [apu_pkg::CHANNEL_BITS-1:0]  green_in;
	logic [apu_pkg::CHANNEL_BITS-1:0]  blue_in;
	logic [apu_pkg::CHANNEL_BITS-1:0]  alpha_in;
	logic                              last_pixel_in;

	modport source (output valid, red_in, green_in, blue_in, alpha_in, last_pixel_in,
		input ready);
	modport sink (input valid, red_in, green_in, blue_in, alpha_in, last_pixel_in,
		output ready);
endinterface

interface apu_result_if;
	logic                              valid;
	logic                              ready;
	logic [apu_pkg::CHANNEL_BITS-1:0]  red_out;
	logic [apu_pkg::CHANNEL_BITS-1:0]  green_out;
	logic [apu_pkg::CHANNEL_BITS-1:0]  blue_out;
	logic [apu_pkg::CHANNEL_BITS-1:0]  alpha_out;
	logic                              last_pixel_out;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, last_pixel_out,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, alpha_out, last_pixel_out,
		output ready);
endinterface

/* src/alpha_premultiply_unit.sv */
// Alpha premultiply unit: converts RGBA pixels between straight and premultiplied alpha.
// Uses apu_pkg and the stream interfaces of apu_ifs.sv.
//
// The unit takes one pixel per clock while the result side does not stall. Each pixel
// passes through the input register, the product stage, the divider stages and the
// output register. The divider stages form the restoring divider used for unpremultiply,
// one quotient bit per stage; premultiply rides through the same stages.
// Each stage holds its pixel on its own when the result side stalls, so empty stages
// keep filling and the input is held off only when every stage is occupied.
// Premultiply is round(c * alpha / max), unpremultiply is round(c * max / alpha)
// saturated to max, and a zero alpha leaves the colors unchanged on unpremultiply.
module alpha_premultiply_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [apu_pkg::ADDR_W-1:0]    paddr,
	input  logic [apu_pkg::DATA_W-1:0]    pwdata,
	output logic [apu_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	apu_pixel_if.sink                     pixel,
	apu_result_if.source                  result
);

	localparam int CB    = apu_pkg::CHANNEL_BITS;
	localparam int NL    = apu_pkg::NUM_LANES;
	localparam int PW    = apu_pkg::PROD_W;
	localparam int NW    = apu_pkg::NUM_W;
	localparam int EW    = apu_pkg::ERR_W;
	localparam logic [CB-1:0] MAXV = apu_pkg::MAXV;
	localparam logic signed [EW-1:0] TWO_MAXV = EW'({MAXV, 1'b0});
	localparam logic [PW:0] HALF = (PW + 1)'(1) << (CB - 1);

	apu_pkg::apu_dir_t direction_q;
	apu_pkg::apu_reg_t reg_idx;

	logic                 vld_s1;
	apu_pkg::apu_pix_t    px_s1;
	logic                 vld_s2;
	apu_pkg::apu_stage_t  mul_s2;
	apu_pkg::apu_stage_t  mul_d;
	logic [CB-1:0]        dvld_s;
	apu_pkg::apu_stage_t  div_s [CB];
	logic [CB:0]          den;
	logic                 res_vld_s;
	apu_pkg::apu_pix_t    res_s;
	apu_pkg::apu_pix_t    res_d;
	logic                 en1;
	logic                 en2;
	logic                 out_en;

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = apu_pkg::apu_reg_t'(paddr[apu_pkg::REG_IDX_LSB]);

	always_comb begin
		unique case (reg_idx)
			apu_pkg::REG_DIRECTION: prdata = apu_pkg::DATA_W'(direction_q);
			default:                prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= apu_pkg::DIR_PREMULTIPLY;
		end else if (psel && penable && pwrite && pready &&
			reg_idx == apu_pkg::REG_DIRECTION) begin
			direction_q <= apu_pkg::apu_dir_t'(pwdata[0]);
		end
	end

	// Stage enables: a stage loads when it is empty or its successor moves on.
	assign out_en      = !res_vld_s || result.ready;
	assign den[CB]     = out_en;
	assign en2         = !vld_s2 || den[0];
	assign en1         = !vld_s1 || en2;
	assign pixel.ready = en1;

	// Stage 1: input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en1) begin
			vld_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && pixel.valid) begin
			px_s1.col[0] <= pixel.red_in;
			px_s1.col[1] <= pixel.green_in;
			px_s1.col[2] <= pixel.blue_in;
			px_s1.alpha  <= pixel.alpha_in;
			px_s1.last   <= pixel.last_pixel_in;
		end
	end

	// Stage 2: products for premultiply, dividend 2*c*max + alpha for unpremultiply.
	always_comb begin
		logic [PW-1:0] cm;
		mul_d       = '0;
		mul_d.alpha = px_s1.alpha;
		mul_d.last  = px_s1.last;
		mul_d.azero = (px_s1.alpha == '0);
		for (int i = 0; i < NL; i++) begin
			cm              = {px_s1.col[i], {CB{1'b0}}} - PW'(px_s1.col[i]);
			mul_d.prod[i]   = PW'(px_s1.col[i]) * PW'(px_s1.alpha);
			mul_d.rem[i]    = {cm, 1'b0} + NW'(px_s1.alpha);
			mul_d.col[i]    = px_s1.col[i];
			mul_d.sat[i]    = (px_s1.col[i] >= px_s1.alpha);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			mul_s2 <= mul_d;
		end
	end

	// Divider stages, one quotient bit each; the first two also round the premultiply.
	for (genvar k = 0; k < CB; k++) begin : g_div
		apu_pkg::apu_stage_t dprev;
		apu_pkg::apu_stage_t dnext;
		logic                vprev;

		if (k == 0) begin : g_first
			assign dprev = mul_s2;
			assign vprev = vld_s2;
		end else begin : g_next
			assign dprev = div_s[k-1];
			assign vprev = dvld_s[k-1];
		end

		always_comb begin
			logic [NW-1:0]          trial;
			logic [PW:0]            psum;
			logic signed [EW-1:0]   lhs;
			logic signed [EW-1:0]   rhs;
			logic signed [EW-1:0]   err;
			dnext = dprev;
			trial = NW'({dprev.alpha, 1'b0}) << (CB - 1 - k);
			psum  = '0;
			lhs   = '0;
			rhs   = '0;
			err   = '0;
			for (int i = 0; i < NL; i++) begin
				if (dprev.rem[i] >= trial) begin
					dnext.rem[i]            = dprev.rem[i] - trial;
					dnext.quo[i][CB-1-k]    = 1'b1;
				end
				if (k == 0) begin
					psum           = {1'b0, dprev.prod[i]} + HALF;
					psum           = psum + (psum >> CB);
					dnext.pre[i]   = psum[PW:CB];
				end else if (k == 1) begin
					lhs = EW'({dprev.prod[i], 1'b0}) + EW'(MAXV);
					rhs = (EW'(dprev.pre[i]) << (CB + 1)) - (EW'(dprev.pre[i]) << 1);
					err = lhs - rhs;
					if (err < 0) begin
						dnext.pre[i] = dprev.pre[i] - 1'b1;
					end else if (err >= TWO_MAXV) begin
						dnext.pre[i] = dprev.pre[i] + 1'b1;
					end
				end
			end
		end

		assign den[k] = !dvld_s[k] || den[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvld_s[k] <= 1'b0;
			end else if (den[k]) begin
				dvld_s[k] <= vprev;
			end
		end

		always_ff @(posedge clk) begin
			if (den[k] && vprev) begin
				div_s[k] <= dnext;
			end
		end
	end

	// Output stage: pick the result of the configured direction.
	always_comb begin
		res_d.alpha = div_s[CB-1].alpha;
		res_d.last  = div_s[CB-1].last;
		for (int i = 0; i < NL; i++) begin
			if (direction_q == apu_pkg::DIR_PREMULTIPLY) begin
				res_d.col[i] = div_s[CB-1].pre[i][CB-1:0];
			end else if (div_s[CB-1].azero) begin
				res_d.col[i] = div_s[CB-1].col[i];
			end else if (div_s[CB-1].sat[i]) begin
				res_d.col[i] = MAXV;
			end else begin
				res_d.col[i] = div_s[CB-1].quo[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s <= 1'b0;
		end else if (out_en) begin
			res_vld_s <= dvld_s[CB-1];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en && dvld_s[CB-1]) begin
			res_s <= res_d;
		end
	end

	assign result.valid          = res_vld_s;
	assign result.red_out        = res_s.col[0];
	assign result.green_out      = res_s.col[1];
	assign result.blue_out       = res_s.col[2];
	assign result.alpha_out      = res_s.alpha;
	assign result.last_pixel_out = res_s.last;

	// A premultiplied color never exceeds its alpha.
	a_premul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && direction_q == apu_pkg::DIR_PREMULTIPLY |->
		result.red_out <= result.alpha_out && result.green_out <= result.alpha_out &&
		result.blue_out <= result.alpha_out)
		else $error("premultiplied color above alpha");

	// The divider leaves a remainder below the divisor on every lane that is not saturated.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		dvld_s[CB-1] && !div_s[CB-1].azero |->
		(div_s[CB-1].sat[0] || div_s[CB-1].rem[0] < NW'({div_s[CB-1].alpha, 1'b0})) &&
		(div_s[CB-1].sat[1] || div_s[CB-1].rem[1] < NW'({div_s[CB-1].alpha, 1'b0})) &&
		(div_s[CB-1].sat[2] || div_s[CB-1].rem[2] < NW'({div_s[CB-1].alpha, 1'b0})))
		else $error("divider remainder out of range");

	// Input is held off only while the result side is stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> result.valid && !result.ready)
		else $error("input stalled without output backpressure");

endmodule
